[sv/m61_pkg.sv]
// m61_pkg: shared types, constants and state codes for the 2^61-1 field unit
// no dependencies
package m61_pkg;

  localparam int unsigned ElemW = 61;
  localparam int unsigned ExpW  = 64;
  localparam logic [ElemW-1:0] FieldP = {ElemW{1'b1}};
  localparam logic [ExpW-1:0]  InvExp = 64'd2305843009213693949;

  typedef enum logic [1:0] {
    CMD_MUL = 2'd0,
    CMD_POW = 2'd1,
    CMD_INV = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [ElemW-1:0] operand_a;
    logic [ElemW-1:0] operand_b;
    logic [ExpW-1:0]  exponent;
  } in_item_t;

  typedef struct packed {
    logic [ElemW-1:0] result;
    logic             zero_divisor;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MULB,
    ST_FINAL,
    ST_DONE
  } state_t;

  // multiplier request/response
  typedef struct packed {
    logic go;
  } mul_req_t;

  typedef struct packed {
    logic done;
  } mul_rsp_t;

  // reduce a 61-bit value that may equal p
  function automatic logic [ElemW-1:0] red61(input logic [ElemW-1:0] v);
    red61 = (v == FieldP) ? '0 : v;
  endfunction

endpackage

[sv/m61_mul.sv]
// m61_mul: multicycle field multiplier modulo 2^61-1
// one 32x32 partial product per cycle, then mersenne fold; uses m61_pkg
module m61_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  m61_pkg::mul_req_t        req,
  input  logic [m61_pkg::ElemW-1:0] x,
  input  logic [m61_pkg::ElemW-1:0] y,
  output m61_pkg::mul_rsp_t        rsp,
  output logic [m61_pkg::ElemW-1:0] p
);

  logic [2:0]   step;
  logic         busy;
  logic [31:0]  op_x, op_y;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [63:0]  s1;
  logic [61:0]  s2;
  logic [61:0]  s3;

  // partial product select: step 0 ll, 1 lh, 2 hl, 3 hh
  always_comb begin
    op_x = step[1] ? {3'b0, x[60:32]} : x[31:0];
    op_y = step[0] ? {3'b0, y[60:32]} : y[31:0];
  end

  always_ff @(posedge clk) begin
    prod <= op_x * op_y;
  end

  // fold: low 61 bits plus the bits above, twice
  always_comb begin
    s1 = {3'b0, acc[60:0]} + {3'b0, acc[121:61]};
    s2 = {1'b0, s1[60:0]} + {59'b0, s1[63:61]};
    s3 = (s2 >= {1'b0, m61_pkg::FieldP}) ? s2 - {1'b0, m61_pkg::FieldP} : s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.go && !busy) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd5) busy <= 1'b0;
    end
  end

  // products arrive in the cycle after their select
  always_ff @(posedge clk) begin
    if (req.go && !busy) acc <= '0;
    else if (busy) begin
      unique case (step)
        3'd1:    acc <= acc + {64'b0, prod};
        3'd2:    acc <= acc + {32'b0, prod, 32'b0};
        3'd3:    acc <= acc + {32'b0, prod, 32'b0};
        3'd4:    acc <= acc + {prod, 64'b0};
        default: acc <= acc;
      endcase
    end
  end

  // product is valid while done is high, acc holds during the last step
  assign p = s3[60:0];

  assign rsp.done = busy && step == 3'd5;

endmodule

[sv/mersenne61_field_unit.sv]
// mersenne61_field_unit: top level, command sequencer around one shared multiplier
// depends on m61_pkg and m61_mul
//
// channel  dir  signals                     handshake
// in       in   in_item (m61_pkg::in_item_t)  start high while busy low
// out      out  out_item (m61_pkg::out_item_t) done strobe, one cycle
//
// each multiply on the shared unit forms 4 partial products, then folds
// multiply: a single multiply; power: 64 squarings plus one multiply per set bit
// inverse: exponent p-2, 60 set bits; divide adds one multiply
// rst is synchronous and returns the sequencer to idle
// results cannot be stalled; busy stays high until the done strobe
module mersenne61_field_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  m61_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               done,
  output m61_pkg::out_item_t out_item
);

  m61_pkg::state_t state, state_next;
  m61_pkg::cmd_t   cmd;
  logic [m61_pkg::ElemW-1:0] a, b, acc, base;
  logic [m61_pkg::ExpW-1:0]  e;
  logic [5:0]  bit_idx;
  logic        zflag;
  logic        launched;
  logic [m61_pkg::ElemW-1:0] mx, my, mp;
  m61_pkg::mul_req_t req;
  m61_pkg::mul_rsp_t rsp;
  logic [m61_pkg::ElemW-1:0] ra, rb;
  logic        accept;

  assign accept = start && !busy;
  assign ra = m61_pkg::red61(in_item.operand_a);
  assign rb = m61_pkg::red61(in_item.operand_b);

  m61_mul u_mul (
    .clk(clk), .rst(rst), .req(req), .x(mx), .y(my), .rsp(rsp), .p(mp)
  );

  // operand routing to the shared multiplier
  always_comb begin
    mx = acc;
    my = acc;
    unique case (state)
      m61_pkg::ST_MULB:  my = base;
      m61_pkg::ST_FINAL: begin
        mx = (cmd == m61_pkg::CMD_MUL) ? a : acc;
        my = (cmd == m61_pkg::CMD_MUL) ? b : a;
      end
      default: ;
    endcase
    req.go = !launched && (state == m61_pkg::ST_SQR || state == m61_pkg::ST_MULB ||
                           state == m61_pkg::ST_FINAL);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      m61_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.command == m61_pkg::CMD_MUL) state_next = m61_pkg::ST_FINAL;
          else if (in_item.command == m61_pkg::CMD_POW) state_next = m61_pkg::ST_SQR;
          else if (in_item.command == m61_pkg::CMD_INV)
            state_next = (ra == '0) ? m61_pkg::ST_DONE : m61_pkg::ST_SQR;
          else state_next = (rb == '0) ? m61_pkg::ST_DONE : m61_pkg::ST_SQR;
        end
      end
      m61_pkg::ST_SQR: if (rsp.done) begin
        if (e[bit_idx]) state_next = m61_pkg::ST_MULB;
        else if (bit_idx == '0)
          state_next = (cmd == m61_pkg::CMD_DIV) ? m61_pkg::ST_FINAL : m61_pkg::ST_DONE;
      end
      m61_pkg::ST_MULB: if (rsp.done) begin
        if (bit_idx == '0)
          state_next = (cmd == m61_pkg::CMD_DIV) ? m61_pkg::ST_FINAL : m61_pkg::ST_DONE;
        else state_next = m61_pkg::ST_SQR;
      end
      m61_pkg::ST_FINAL: if (rsp.done) state_next = m61_pkg::ST_DONE;
      m61_pkg::ST_DONE:  state_next = m61_pkg::ST_IDLE;
      default:           state_next = m61_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != m61_pkg::ST_IDLE);
    done = (state == m61_pkg::ST_DONE);
    out_item.result = zflag ? '0 : acc;
    out_item.zero_divisor = zflag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= m61_pkg::ST_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.done || state_next != state) launched <= 1'b0;
      else if (req.go) launched <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= m61_pkg::cmd_t'(in_item.command);
      a       <= ra;
      b       <= rb;
      acc     <= {{(m61_pkg::ElemW-1){1'b0}}, 1'b1};
      bit_idx <= '1;
      zflag   <= 1'b0;
      unique case (m61_pkg::cmd_t'(in_item.command))
        m61_pkg::CMD_MUL: begin base <= rb; e <= '0; end
        m61_pkg::CMD_POW: begin base <= rb; e <= in_item.exponent; end
        m61_pkg::CMD_INV: begin
          base <= ra; e <= m61_pkg::InvExp; zflag <= (ra == '0);
        end
        m61_pkg::CMD_DIV: begin
          base <= rb; e <= m61_pkg::InvExp; zflag <= (rb == '0);
        end
        default: ;
      endcase
    end else if (rsp.done) begin
      acc <= mp;
      if ((state == m61_pkg::ST_SQR && !e[bit_idx]) || state == m61_pkg::ST_MULB)
        bit_idx <= bit_idx - 6'd1;
    end
  end

  // one multiply per done in a compute state
  // inverse and divide items with a zero divisor go straight from the accept cycle to done
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start)) else $error("done without work");
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    done && out_item.zero_divisor |-> out_item.result == '0)
    else $error("zero divisor with nonzero result");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
  a_mul_only_compute: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> busy && !done) else $error("multiplier done outside compute");

endmodule
